// ===== rtl/core/mfd_pkg.sv =====
package mfd_pkg;

  // Item field widths
  localparam int unsigned PIX_BITS  = 12;
  localparam int unsigned BLUE_BITS = 8;
  localparam int unsigned SUM_BITS  = 32;

  // Register file
  localparam int unsigned ZONE_BITS  = 48;
  localparam int unsigned ZONE_REGS  = 4;
  localparam int unsigned CNT_BITS   = 3;
  localparam int unsigned DATA_BITS  = 64;
  localparam int unsigned ADDR_BITS  = 6;
  localparam int unsigned INDEX_BITS = 3;

  typedef logic [INDEX_BITS-1:0] reg_index_t;

  localparam reg_index_t REG_THRESHOLD  = 3'd0;
  localparam reg_index_t REG_ZONE_COUNT = 3'd1;
  localparam reg_index_t REG_ZONE_FIRST = 3'd2;

  localparam logic [SUM_BITS-1:0] THRESHOLD_RESET = 32'd1;

endpackage

// ===== rtl/core/mfd_if.sv =====
interface mfd_pix_if import mfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_BITS-1:0]  pixel_x;
  logic [PIX_BITS-1:0]  pixel_y;
  logic [BLUE_BITS-1:0] prev_blue;
  logic [BLUE_BITS-1:0] curr_blue;
  logic                 frame_end;

  modport source (output valid, pixel_x, pixel_y, prev_blue, curr_blue, frame_end,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, prev_blue, curr_blue, frame_end,
                  output ready);
endinterface

interface mfd_res_if import mfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                motion_found;
  logic [SUM_BITS-1:0] difference_sum;

  modport source (output valid, motion_found, difference_sum, input ready);
  modport sink   (input valid, motion_found, difference_sum, output ready);
endinterface

// ===== rtl/core/masked_frame_difference_motion_core.sv =====
// Channel   Direction  Carries
// -------   ---------  ---------------------------------------------------
// pix       in         pixel_x, pixel_y, prev_blue, curr_blue, frame_end
// res       out        motion_found, difference_sum (one per frame_end item)
// apb       cfg        threshold, zone count, zone_0..zone_3 at 8*index
//
// One pixel item per cycle sustained. A result is valid once its frame_end
// item leaves the input register: the item sits there, and the zone test,
// difference and saturating add then load the result register.
// rst (synchronous) clears the input register valid flag, the running sum, the
// result valid flag, the zone count and the zones, and sets the threshold to 1.
// Only a frame_end item stalls: it waits in the input register while the
// previous result is still held, and pix.ready stays low until res takes it.
module masked_frame_difference_motion_core
  import mfd_pkg::*;
#(
  parameter int unsigned MAX_ZONES  = 4,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  mfd_pix_if.sink              pix,
  mfd_res_if.source            res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  // Only the first ZONE_REGS rectangles have registers at all.
  localparam int unsigned NUM_ZONES = (MAX_ZONES < ZONE_REGS) ? MAX_ZONES : ZONE_REGS;
  // Common compare width for pixel coordinates and rectangle corners.
  localparam int unsigned CMP_BITS  = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SUM_BITS-1:0]  threshold;
  logic [CNT_BITS-1:0]  zone_count;
  logic [ZONE_BITS-1:0] zone [NUM_ZONES];

  logic       cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[ADDR_BITS-1 -: INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      zone_count <= '0;
      for (int z = 0; z < NUM_ZONES; z++) zone[z] <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_THRESHOLD) threshold <= pwdata[SUM_BITS-1:0];
      if (cfg_index == REG_ZONE_COUNT) zone_count <= pwdata[CNT_BITS-1:0];
      // zones past NUM_ZONES have no register, so their writes drop
      for (int z = 0; z < NUM_ZONES; z++) begin
        if (cfg_index == REG_ZONE_FIRST + INDEX_BITS'(z)) zone[z] <= pwdata[ZONE_BITS-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_index == REG_THRESHOLD) prdata = DATA_BITS'(threshold);
    if (cfg_index == REG_ZONE_COUNT) prdata = DATA_BITS'(zone_count);
    for (int z = 0; z < NUM_ZONES; z++) begin
      if (cfg_index == REG_ZONE_FIRST + INDEX_BITS'(z)) prdata = DATA_BITS'(zone[z]);
    end
  end

  // ---------------------------------------------------------------------
  // Input register and flow control. Only a frame_end item in the input
  // register can stall, and only when the result register is still held.
  // ---------------------------------------------------------------------
  logic                 s1_valid, out_valid;
  logic                 s1_move, s1_free;
  logic [PIX_BITS-1:0]  s1_x, s1_y;
  logic [BLUE_BITS-1:0] s1_prev, s1_curr;
  logic                 s1_last;

  assign s1_move   = s1_valid && (!s1_last || !out_valid || res.ready);
  assign s1_free   = !s1_valid || s1_move;
  assign pix.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && s1_free) begin
      s1_x    <= pix.pixel_x;
      s1_y    <= pix.pixel_y;
      s1_prev <= pix.prev_blue;
      s1_curr <= pix.curr_blue;
      s1_last <= pix.frame_end;
    end
  end

  // ---------------------------------------------------------------------
  // Zone test and absolute difference
  // ---------------------------------------------------------------------
  logic [NUM_ZONES-1:0] zone_hit;
  logic [CMP_BITS-1:0]  px, py;

  assign px = CMP_BITS'(s1_x);
  assign py = CMP_BITS'(s1_y);

  for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
    logic [DATA_BITS-1:0] packed_zone;
    logic [CMP_BITS-1:0]  xa, ya, xb, yb, xl, xh, yl, yh;

    // corners beyond the 48 stored bits read as zero
    assign packed_zone = DATA_BITS'(zone[z]);
    assign xa = CMP_BITS'(packed_zone[0*COORD_BITS +: COORD_BITS]);
    assign ya = CMP_BITS'(packed_zone[1*COORD_BITS +: COORD_BITS]);
    assign xb = CMP_BITS'(packed_zone[2*COORD_BITS +: COORD_BITS]);
    assign yb = CMP_BITS'(packed_zone[3*COORD_BITS +: COORD_BITS]);
    assign xl = (xa < xb) ? xa : xb;
    assign xh = (xa < xb) ? xb : xa;
    assign yl = (ya < yb) ? ya : yb;
    assign yh = (ya < yb) ? yb : ya;

    assign zone_hit[z] = (CNT_BITS'(z) < zone_count) &&
                         (px >= xl) && (px <= xh) && (py >= yl) && (py <= yh);
  end

  logic [BLUE_BITS-1:0] abs_diff;
  logic [BLUE_BITS-1:0] pix_diff;
  assign abs_diff = (s1_prev > s1_curr) ? (s1_prev - s1_curr) : (s1_curr - s1_prev);
  // masked pixels add nothing
  assign pix_diff = (|zone_hit) ? '0 : abs_diff;

  // ---------------------------------------------------------------------
  // Saturating accumulate and result register
  // ---------------------------------------------------------------------
  logic [SUM_BITS-1:0] running_sum;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_next;
  logic                load_result;
  logic                motion_found;
  logic [SUM_BITS-1:0] difference_sum;

  assign sum_wide    = {1'b0, running_sum} + (SUM_BITS + 1)'(pix_diff);
  assign sum_next    = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
  assign load_result = s1_move && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s1_move) running_sum <= s1_last ? '0 : sum_next;
      if (load_result) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      motion_found   <= (sum_next > threshold);
      difference_sum <= sum_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.motion_found   = motion_found;
  assign res.difference_sum = difference_sum;

`ifndef NO_ASSERTIONS
  // a new result only appears after a frame_end item was consumed
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(load_result))
    else $error("result valid without a frame_end item");

  // the sum restarts at zero after each frame
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (running_sum == '0))
    else $error("running sum not cleared at frame end");

  // saturating sum never goes down within a frame
  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_last) |=> (running_sum >= $past(running_sum)))
    else $error("running sum wrapped");

  // input side only backs up behind a held result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !pix.ready |-> (s1_valid && s1_last && out_valid && !res.ready))
    else $error("input stalled without a held result");
`endif

endmodule
